FILE: hdl/calendar_to_bcd_with_weekday_assert.svh
// Assertion macros used by the checker file.
`ifndef CALENDAR_TO_BCD_WITH_WEEKDAY_ASSERT_SVH
`define CALENDAR_TO_BCD_WITH_WEEKDAY_ASSERT_SVH

// Same-cycle implication.
`define CTBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ctbw_pkg.sv
package ctbw_pkg;

    localparam int InDataW  = 40;
    localparam int OutDataW = 48;
    localparam int ResultW  = 42;

    // 2483 mod 7: day count constant for the year 1999 reference plus the
    // fixed quotient terms of the leap-day sum.
    localparam logic [9:0] YearBase = 10'd5;
    localparam logic [6:0] YearNoLeap = 7'd100;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_item;

    typedef struct packed {
        logic       range_error;
        logic [2:0] weekday;
        logic [6:0] second_bcd;
        logic [6:0] minute_bcd;
        logic [5:0] hour_bcd;
        logic [5:0] day_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
    } t_result;

    // Two packed BCD digits; tens via multiply by 205 and shift by 11.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {8'd0, v} * 15'd205;
        tens  = prod[14:11];
        units = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
        return {tens, units[3:0]};
    endfunction

    // Days before the first of month m in a common year; months past
    // December count as 31 days each.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Residue mod 7 by folding octal digits (8 = 1 mod 7).
    function automatic logic [2:0] mod7(input logic [9:0] s);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = {4'd0, s[9]} + {2'd0, s[8:6]} + {2'd0, s[5:3]} + {2'd0, s[2:0]};
        f2 = {2'd0, f1[4:3]} + {1'b0, f1[2:0]};
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

endpackage

FILE: hdl/ctbw_conv.sv
module ctbw_conv (
    input  ctbw_pkg::t_item   i_item,
    output ctbw_pkg::t_result o_result
);

    logic [7:0] yr_p3;
    logic [5:0] leap_q;
    logic       leap;
    logic [8:0] cum;
    logic [9:0] count;
    logic [2:0] rem;
    logic [7:0] yr_bcd;
    logic [7:0] mo_bcd;
    logic [7:0] dy_bcd;
    logic [7:0] hr_bcd;
    logic [7:0] mi_bcd;
    logic [7:0] se_bcd;

    always_comb begin
        leap   = (i_item.year[1:0] == 2'b00) && (i_item.year != ctbw_pkg::YearNoLeap);
        yr_p3  = {1'b0, i_item.year} + 8'd3;
        leap_q = yr_p3[7:2];
        cum    = ctbw_pkg::days_before(i_item.month)
               + {8'd0, leap && (i_item.month >= 4'd3)};
        count  = {3'd0, i_item.year} + {4'd0, leap_q} + {1'b0, cum}
               + {5'd0, i_item.day} + ctbw_pkg::YearBase
               - {9'd0, i_item.year > ctbw_pkg::YearNoLeap};
        rem    = ctbw_pkg::mod7(count);

        yr_bcd = ctbw_pkg::to_bcd(i_item.year);
        mo_bcd = ctbw_pkg::to_bcd({3'd0, i_item.month});
        dy_bcd = ctbw_pkg::to_bcd({2'd0, i_item.day});
        hr_bcd = ctbw_pkg::to_bcd({2'd0, i_item.hour});
        mi_bcd = ctbw_pkg::to_bcd({1'b0, i_item.minute});
        se_bcd = ctbw_pkg::to_bcd({1'b0, i_item.second});

        o_result.year_bcd    = yr_bcd;
        o_result.month_bcd   = mo_bcd[4:0];
        o_result.day_bcd     = dy_bcd[5:0];
        o_result.hour_bcd    = hr_bcd[5:0];
        o_result.minute_bcd  = mi_bcd[6:0];
        o_result.second_bcd  = se_bcd[6:0];
        o_result.weekday     = (rem == 3'd0) ? 3'd7 : rem;
        o_result.range_error = (i_item.year > 7'd99) || (i_item.month == 4'd0)
                             || (i_item.month > 4'd12) || (i_item.day == 5'd0)
                             || (i_item.hour > 5'd23) || (i_item.minute > 6'd59)
                             || (i_item.second > 6'd59);
    end

endmodule

FILE: hdl/calendar_to_bcd_with_weekday.sv
// Channel   Direction  tdata                                   tuser
// s_axis    in         year, month, day, hour, minute, second  -
// m_axis    out        year..second BCD, weekday               range_error
//
// An input transaction passes an input register, one pass of conversion
// logic and a result register before its result transaction is offered.
// A new transaction is taken every cycle while the result side keeps up.
// A stalled result holds; an empty input register still fills while it waits.
// Reset is synchronous, active low, and clears the two valid flags only.
module calendar_to_bcd_with_weekday (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // year[6:0], month[10:7], day[15:11], hour[20:16], minute[26:21],
    // second[32:27], zero[39:33]
    input  logic [ctbw_pkg::InDataW-1:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // year_bcd[7:0], month_bcd[12:8], day_bcd[18:13], hour_bcd[24:19],
    // minute_bcd[31:25], second_bcd[38:32], weekday[41:39], zero[47:42]
    output logic [ctbw_pkg::OutDataW-1:0] o_m_axis_tdata,
    // range_error[0]
    output logic        o_m_axis_tuser
);

    ctbw_pkg::t_item   r_in;
    logic              r_in_valid;
    ctbw_pkg::t_result r_out;
    logic              r_out_valid;
    ctbw_pkg::t_result n_out;
    logic              out_load;
    logic              in_load;

    ctbw_conv u_conv (
        .i_item   (r_in),
        .o_result (n_out)
    );

    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign in_load         = !r_in_valid || out_load;
    assign o_s_axis_tready = in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_s_axis_tvalid) begin
            r_in <= ctbw_pkg::t_item'(i_s_axis_tdata[$bits(ctbw_pkg::t_item)-1:0]);
        end
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(ctbw_pkg::OutDataW - ctbw_pkg::ResultW)'(0),
                              r_out[ctbw_pkg::ResultW-1:0]};
    assign o_m_axis_tuser  = r_out.range_error;

endmodule

FILE: hdl/ctbw_checker.sv
`include "calendar_to_bcd_with_weekday_assert.svh"

module ctbw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          i_s_axis_tready,
    input logic                          i_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ctbw_pkg::OutDataW-1:0] i_m_axis_tdata,
    input logic                          i_m_axis_tuser
);

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid && i_s_axis_tready;

    // stalled result holds
    `CTBW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser), "result changed while stalled")

    // input transaction shows up as a valid result, through both registers, when the sink is ready
    `CTBW_ASSERT_NEXT(a_latency, i_clk, i_rst_n, in_xfer ##1 i_m_axis_tready, i_m_axis_tvalid, "result missing after transaction")

    // weekday never zero
    `CTBW_ASSERT_NOW(a_weekday, i_clk, i_rst_n, i_m_axis_tvalid, i_m_axis_tdata[41:39] != 3'd0, "weekday out of range")

    // in-range items give decimal digits
    `CTBW_ASSERT_NOW(a_bcd_digit, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tuser, i_m_axis_tdata[35:32] <= 4'd9 && i_m_axis_tdata[3:0] <= 4'd9, "bad BCD digit")

endmodule

bind calendar_to_bcd_with_weekday ctbw_checker u_ctbw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);
